// File: rtl/bdq_pkg.sv
// bdq_pkg: sizes, operation codes and cell command type for the bounded deque
// used by bdq_cell, bounded_double_ended_queue_unit and bdq_checker
package bdq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 5;
    localparam int ENTRY_W = 5;
    localparam int LIM_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t EMPTY_WORD = '1;

    typedef enum logic [1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_REAR  = 2'd1,
        OP_DEL_FRONT = 2'd2,
        OP_DEL_REAR  = 2'd3
    } op_t;

    // one cell's update for this cycle; at most one bit is set
    typedef struct packed {
        logic from_left;
        logic from_right;
        logic load;
    } cell_cmd_t;

endpackage

// File: rtl/bdq_cell.sv
// bdq_cell: one word of the deque, shifts toward either neighbor or loads a new word
// depends on bdq_pkg
module bdq_cell
    import bdq_pkg::*;
(
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  word_t     left_data,
    input  word_t     right_data,
    input  word_t     load_data,
    output word_t     data_q
);

    word_t data_reg;
    word_t data_next;

    always_comb begin
        data_next = data_reg;
        if (cmd.from_left) begin
            data_next = left_data;
        end else if (cmd.from_right) begin
            data_next = right_data;
        end else if (cmd.load) begin
            data_next = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

// File: rtl/bounded_double_ended_queue_unit.sv
// bounded_double_ended_queue_unit: top level, a row of bdq_cell words with cell 0 at the front
// depends on bdq_pkg and bdq_cell
//
//   channel | handshake        | payload
//   s_      | s_valid/s_ready  | s_op, s_value
//   m_      | m_valid/m_ready  | m_ok, m_front_value, m_rear_value, m_is_empty,
//           |                  | m_is_full, m_entry_count
//   cfg_    | cfg_we           | cfg_wdata (capacity)
//
// one item per clock while each result is taken: the cells and the count update at the
// accepting edge and the result shows in the next cycle, read straight from the cell row
// an item can be taken in the same cycle as the previous result is taken
// while a result waits with m_ready low, s_ready stays low
// reset (aresetn low, synchronous) empties the deque and sets capacity to 16;
// the cell contents are not cleared
module bounded_double_ended_queue_unit
    import bdq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CAP_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  word_t              s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_ok,
    output word_t              m_front_value,
    output word_t              m_rear_value,
    output logic               m_is_empty,
    output logic               m_is_full,
    output logic [ENTRY_W-1:0] m_entry_count
);

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             ok_reg;

    word_t     cell_q   [DEPTH];
    cell_cmd_t cell_cmd [DEPTH];

    logic             accept;
    logic [LIM_W-1:0] limit;
    logic             full_now;
    logic             empty_now;
    logic             do_ins_front;
    logic             do_ins_rear;
    logic             do_del_front;
    logic             do_del_rear;
    logic             op_ok;
    op_t              op;
    logic [IDX_W-1:0] rear_idx;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign op      = op_t'(s_op);

    // capacity above the store depth saturates
    assign limit = (LIM_W'(cap_reg) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(cap_reg);

    assign full_now  = LIM_W'(count_reg) >= limit;
    assign empty_now = (count_reg == '0);

    always_comb begin
        do_ins_front = 1'b0;
        do_ins_rear  = 1'b0;
        do_del_front = 1'b0;
        do_del_rear  = 1'b0;
        case (op)
            OP_INS_FRONT: do_ins_front = accept && !full_now;
            OP_INS_REAR:  do_ins_rear  = accept && !full_now;
            OP_DEL_FRONT: do_del_front = accept && !empty_now;
            OP_DEL_REAR:  do_del_rear  = accept && !empty_now;
            default:      do_del_rear  = 1'b0;
        endcase
    end

    assign op_ok = do_ins_front || do_ins_rear || do_del_front || do_del_rear;

    always_comb begin
        count_next = count_reg;
        if (do_ins_front || do_ins_rear) begin
            count_next = count_reg + 1'b1;
        end else if (do_del_front || do_del_rear) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            ok_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
                ok_reg      <= op_ok;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // front insert shifts the row rearward, front delete shifts it forward,
    // rear insert loads the first unused cell
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            word_t left_d;
            word_t right_d;

            if (gi == 0) begin : g_first
                assign left_d = s_value;
            end else begin : g_mid
                assign left_d = cell_q[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign right_d = cell_q[gi];
            end else begin : g_inner
                assign right_d = cell_q[gi+1];
            end

            assign cell_cmd[gi].from_left  = do_ins_front;
            assign cell_cmd[gi].from_right = do_del_front;
            assign cell_cmd[gi].load       = do_ins_rear && (count_reg == CNT_W'(gi));

            bdq_cell u_cell (
                .aclk       (aclk),
                .cmd        (cell_cmd[gi]),
                .left_data  (left_d),
                .right_data (right_d),
                .load_data  (s_value),
                .data_q     (cell_q[gi])
            );
        end
    endgenerate

    assign rear_idx = IDX_W'(count_reg - 1'b1);

    assign m_valid       = m_valid_reg;
    assign m_ok          = ok_reg;
    assign m_is_empty    = empty_now;
    assign m_is_full     = full_now;
    assign m_entry_count = ENTRY_W'(count_reg);
    assign m_front_value = empty_now ? EMPTY_WORD : cell_q[0];
    assign m_rear_value  = empty_now ? EMPTY_WORD : cell_q[rear_idx];

endmodule

// File: rtl/bdq_checker.sv
// bdq_checker: port-level checks on the deque result channel, bound to the top level
// depends on bdq_pkg and bounded_double_ended_queue_unit
module bdq_checker
    import bdq_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_ok,
    input word_t              m_front_value,
    input word_t              m_rear_value,
    input logic               m_is_empty,
    input logic               m_is_full,
    input logic [ENTRY_W-1:0] m_entry_count
);

    // count never exceeds the store
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entry_count <= ENTRY_W'(DEPTH)))
        else $error("entry count above depth");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> (m_front_value == EMPTY_WORD
                                     && m_rear_value == EMPTY_WORD))
        else $error("empty deque shows a word");

    // with one entry held, front and rear are the same cell
    a_single_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_entry_count == ENTRY_W'(1)) |-> (m_front_value == m_rear_value))
        else $error("single entry with front and rear apart");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_front_value)
                                   && $stable(m_entry_count) && $stable(m_ok)))
        else $error("stalled result changed");

endmodule

bind bounded_double_ended_queue_unit bdq_checker u_bdq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_ok          (m_ok),
    .m_front_value (m_front_value),
    .m_rear_value  (m_rear_value),
    .m_is_empty    (m_is_empty),
    .m_is_full     (m_is_full),
    .m_entry_count (m_entry_count)
);
